/* rtl/core/fan_curve_and_tach_rpm_macros.svh */
// Assertion macros shared by the fan controller RTL.
// Defining NO_ASSERTIONS compiles every use of them to nothing.
`ifndef FAN_CURVE_AND_TACH_RPM_MACROS_SVH
`define FAN_CURVE_AND_TACH_RPM_MACROS_SVH

`ifndef NO_ASSERTIONS
`define FCR_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fan controller assertion failed");
`define FCR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fan controller assertion failed");
`else
`define FCR_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define FCR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* rtl/core/fcr_pkg.sv */
// Types and constants of the fan curve and tachometer core.
// No dependencies; used by every module of the core.
`default_nettype none

package fcr_pkg;

   localparam logic [1:0] FUNC_TEMP    = 2'd0;
   localparam logic [1:0] FUNC_TACH    = 2'd1;
   localparam logic [1:0] FUNC_MEASURE = 2'd2;

   localparam logic KIND_DUTY = 1'b0;
   localparam logic KIND_RPM  = 1'b1;

   localparam logic REG_TEMP_LOW  = 1'b0;
   localparam logic REG_TEMP_HIGH = 1'b1;

   localparam logic signed [11:0] TEMP_LOW_RESET  = 12'sd400;
   localparam logic signed [11:0] TEMP_HIGH_RESET = 12'sd640;
   localparam logic signed [11:0] TEMP_FLOOR      = -12'sd800;
   localparam logic signed [11:0] TEMP_ERR_HOT    = 12'sd1360;
   localparam logic signed [11:0] TEMP_ERR_COLD   = -12'sd2032;

   localparam logic [7:0]  DUTY_BASE  = 8'd51;
   localparam logic [7:0]  DUTY_SPAN  = 8'd204;
   localparam logic [7:0]  DUTY_FULL  = 8'd255;
   localparam logic [9:0]  PWM_FULL   = 10'd1000;
   localparam logic [15:0] RPM_SCALE  = 16'd60000;
   localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
   localparam logic [15:0] RPM_MAX    = 16'hFFFF;

   localparam int DIV_NUM_W  = 32;
   localparam int DIV_DEN_W  = 17;
   localparam int DIV_STEP_W = $clog2(DIV_NUM_W);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DUTY,
      ST_DUTY_DIV,
      ST_PWM,
      ST_PWM_DIV,
      ST_DUTY_OUT,
      ST_RPM,
      ST_RPM_DIV,
      ST_RPM_OUT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef struct packed {
      logic inc;
      logic clr;
   } tach_ctrl_type;

endpackage

`default_nettype wire

/* rtl/core/fcr_serial_div.sv */
// Restoring divider that produces one quotient bit per cycle.
// Depends on fcr_pkg for its widths and the status struct.
`default_nettype none

module fcr_serial_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [fcr_pkg::DIV_NUM_W-1:0]  num,
   input  wire logic [fcr_pkg::DIV_DEN_W-1:0]  den,
   output fcr_pkg::div_stat_type               stat,
   output logic [fcr_pkg::DIV_NUM_W-1:0]       quo
);
   import fcr_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic [DIV_NUM_W-1:0]  nq_ff, nq_in;
   logic [DIV_DEN_W-1:0]  rem_ff, rem_in;
   logic [DIV_DEN_W-1:0]  den_ff, den_in;
   logic [DIV_DEN_W:0]    trial;
   logic [DIV_DEN_W:0]    trial_sub;
   logic                  fits;

   assign trial     = {rem_ff, nq_ff[DIV_NUM_W-1]};
   assign trial_sub = trial - {1'b0, den_ff};
   assign fits      = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      nq_in   = nq_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         nq_in   = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in  = fits ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         nq_in   = {nq_ff[DIV_NUM_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == DIV_STEP_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      nq_ff  <= nq_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quo       = nq_ff;

endmodule

`default_nettype wire

/* rtl/core/fcr_tach_bank.sv */
// Saturating tachometer pulse counters, one per fan.
// Depends on fcr_pkg for the control struct and count limit.
`default_nettype none

module fcr_tach_bank #(
   parameter int FAN_COUNT = 2,
   parameter int IDX_W     = 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire fcr_pkg::tach_ctrl_type ctrl,
   input  wire logic [IDX_W-1:0]      sel,
   output logic [15:0]                count
);
   import fcr_pkg::*;

   logic [15:0] cnt_ff [FAN_COUNT];
   logic [15:0] cnt_in [FAN_COUNT];

   always_comb begin
      for (int i = 0; i < FAN_COUNT; i++) begin
         cnt_in[i] = cnt_ff[i];
         if (sel == IDX_W'(i)) begin
            if (ctrl.clr) begin
               cnt_in[i] = '0;
            end else if (ctrl.inc && cnt_ff[i] != COUNT_MAX) begin
               cnt_in[i] = cnt_ff[i] + 16'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < FAN_COUNT; i++) begin
         if (reset) begin
            cnt_ff[i] <= '0;
         end else begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   assign count = cnt_ff[sel];

endmodule

`default_nettype wire

/* rtl/core/fan_curve_and_tach_rpm.sv */
// Temperature: one result after two divisions, or after one division at a saturated duty.
// Measure: one result per fan in fan order; a zero window gives the maximum rpm undivided.
// Tach: counted at acceptance, no result. A new transaction is accepted the cycle after the
// last result loads.
// Synchronous reset restores temp_low 400, temp_high 640, temperature 0 and clears counters.
// Depends on fcr_pkg, fcr_serial_div (one bit per cycle), fcr_tach_bank and the macro header.
`default_nettype none
`include "fan_curve_and_tach_rpm_macros.svh"

module fan_curve_and_tach_rpm #(
   parameter int FAN_COUNT = 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [2:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_func,
   input  wire logic signed [11:0] req_temp_sample,
   input  wire logic               req_fan_select,
   input  wire logic [15:0]        req_window_ms,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_kind,
   output logic                    rsp_sample_ok,
   output logic [7:0]              rsp_duty_byte,
   output logic [9:0]              rsp_pwm_level,
   output logic                    rsp_fan_id,
   output logic [15:0]             rsp_rpm_value,
   output logic                    rsp_last
);
   import fcr_pkg::*;

   localparam int IDX_W = (FAN_COUNT > 1) ? $clog2(FAN_COUNT) : 1;

   state_type state_ff, state_in;

   logic signed [11:0] temp_low_ff, temp_high_ff, cur_temp_ff, cur_temp_in;
   logic               ok_ff, ok_in;
   logic [7:0]         duty_ff, duty_in;
   logic [9:0]         pwm_ff, pwm_in;
   logic [15:0]        rpm_ff, rpm_in;
   logic [15:0]        win_ff, win_in;
   logic [IDX_W-1:0]   fan_idx_ff, fan_idx_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_ok_ff, rsp_fan_ff, rsp_last_ff;
   logic [7:0]         rsp_duty_ff;
   logic [9:0]         rsp_pwm_ff;
   logic [15:0]        rsp_rpm_ff;

   logic                  accept, cfg_wr, sample_ok, fan_ok, is_last, out_free, out_load;
   logic                  div_start, div_wait, duty_load;
   logic [DIV_NUM_W-1:0]  div_num, div_quo;
   logic [DIV_DEN_W-1:0]  div_den;
   div_stat_type          div_stat;
   tach_ctrl_type         tach_ctrl;
   logic [IDX_W-1:0]      tach_sel;
   logic [15:0]           tach_count;
   logic [11:0]           temp_diff, temp_span;

   assign pready    = 1'b1;
   assign cfg_wr    = psel && penable && pwrite;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign sample_ok = (req_temp_sample > TEMP_FLOOR) && (req_temp_sample != TEMP_ERR_HOT)
                      && (req_temp_sample != TEMP_ERR_COLD);
   assign fan_ok    = (32'(req_fan_select) < FAN_COUNT);
   assign is_last   = (fan_idx_ff == IDX_W'(FAN_COUNT - 1));
   assign temp_diff = 12'(cur_temp_ff - temp_low_ff);
   assign temp_span = 12'(temp_high_ff - temp_low_ff);
   assign tach_sel  = (state_ff == ST_IDLE) ? IDX_W'(req_fan_select) : fan_idx_ff;
   assign div_wait  = (state_ff == ST_DUTY_DIV) || (state_ff == ST_PWM_DIV)
                      || (state_ff == ST_RPM_DIV);
   assign duty_load = out_load && (state_ff == ST_DUTY_OUT);

   always_comb begin
      unique case (paddr[2])
         REG_TEMP_LOW:  prdata = 32'(temp_low_ff);
         REG_TEMP_HIGH: prdata = 32'(temp_high_ff);
         default:       prdata = '0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_func == FUNC_TEMP) begin
               state_in = ST_DUTY;
            end else if (accept && req_func == FUNC_MEASURE) begin
               state_in = ST_RPM;
            end
         end
         ST_DUTY: begin
            if (cur_temp_ff >= temp_high_ff || cur_temp_ff <= temp_low_ff) begin
               state_in = ST_PWM;
            end else begin
               state_in = ST_DUTY_DIV;
            end
         end
         ST_DUTY_DIV: if (div_stat.done) state_in = ST_PWM;
         ST_PWM:      state_in = ST_PWM_DIV;
         ST_PWM_DIV:  if (div_stat.done) state_in = ST_DUTY_OUT;
         ST_DUTY_OUT: if (out_free) state_in = ST_IDLE;
         ST_RPM:      state_in = (win_ff == '0) ? ST_RPM_OUT : ST_RPM_DIV;
         ST_RPM_DIV:  if (div_stat.done) state_in = ST_RPM_OUT;
         ST_RPM_OUT: begin
            if (out_free) begin
               state_in = is_last ? ST_IDLE : ST_RPM;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cur_temp_in   = cur_temp_ff;
      ok_in         = ok_ff;
      duty_in       = duty_ff;
      pwm_in        = pwm_ff;
      rpm_in        = rpm_ff;
      win_in        = win_ff;
      fan_idx_in    = fan_idx_ff;
      div_start     = 1'b0;
      div_num       = '0;
      div_den       = '0;
      tach_ctrl.inc = 1'b0;
      tach_ctrl.clr = 1'b0;
      out_load      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority case (req_func)
                  FUNC_TEMP: begin
                     ok_in = sample_ok;
                     if (sample_ok) cur_temp_in = req_temp_sample;
                  end
                  FUNC_TACH:    tach_ctrl.inc = fan_ok;
                  FUNC_MEASURE: begin
                     win_in     = req_window_ms;
                     fan_idx_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_DUTY: begin
            if (cur_temp_ff >= temp_high_ff) begin
               duty_in = DUTY_FULL;
            end else if (cur_temp_ff <= temp_low_ff) begin
               duty_in = '0;
            end else begin
               div_start = 1'b1;
               div_num   = DIV_NUM_W'(temp_diff) * DIV_NUM_W'(DUTY_SPAN);
               div_den   = DIV_DEN_W'(temp_span);
            end
         end
         ST_DUTY_DIV: if (div_stat.done) duty_in = DUTY_BASE + div_quo[7:0];
         ST_PWM: begin
            div_start = 1'b1;
            div_num   = DIV_NUM_W'(duty_ff) * DIV_NUM_W'(PWM_FULL);
            div_den   = DIV_DEN_W'(DUTY_FULL);
         end
         ST_PWM_DIV:  if (div_stat.done) pwm_in = div_quo[9:0];
         ST_DUTY_OUT: out_load = out_free;
         ST_RPM: begin
            if (win_ff == '0) begin
               rpm_in = RPM_MAX;
            end else begin
               div_start = 1'b1;
               div_num   = DIV_NUM_W'(tach_count) * DIV_NUM_W'(RPM_SCALE);
               div_den   = {win_ff, 1'b0};
            end
         end
         ST_RPM_DIV: begin
            if (div_stat.done) begin
               rpm_in = (|div_quo[DIV_NUM_W-1:16]) ? RPM_MAX : div_quo[15:0];
            end
         end
         ST_RPM_OUT: begin
            if (out_free) begin
               out_load      = 1'b1;
               tach_ctrl.clr = 1'b1;
               if (!is_last) fan_idx_in = fan_idx_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         temp_low_ff  <= TEMP_LOW_RESET;
         temp_high_ff <= TEMP_HIGH_RESET;
         cur_temp_ff  <= '0;
         fan_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_temp_ff  <= cur_temp_in;
         fan_idx_ff   <= fan_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cfg_wr) begin
            unique case (paddr[2])
               REG_TEMP_LOW:  temp_low_ff  <= pwdata[11:0];
               REG_TEMP_HIGH: temp_high_ff <= pwdata[11:0];
               default: ;
            endcase
         end
      end
      ok_ff   <= ok_in;
      duty_ff <= duty_in;
      pwm_ff  <= pwm_in;
      rpm_ff  <= rpm_in;
      win_ff  <= win_in;
      if (out_load) begin
         if (state_ff == ST_DUTY_OUT) begin
            rsp_kind_ff <= KIND_DUTY;
            rsp_ok_ff   <= ok_ff;
            rsp_duty_ff <= duty_ff;
            rsp_pwm_ff  <= pwm_ff;
            rsp_fan_ff  <= 1'b0;
            rsp_rpm_ff  <= '0;
            rsp_last_ff <= 1'b1;
         end else begin
            rsp_kind_ff <= KIND_RPM;
            rsp_ok_ff   <= 1'b0;
            rsp_duty_ff <= '0;
            rsp_pwm_ff  <= '0;
            rsp_fan_ff  <= fan_idx_ff[0];
            rsp_rpm_ff  <= rpm_ff;
            rsp_last_ff <= is_last;
         end
      end
   end

   fcr_serial_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .stat  (div_stat),
      .quo   (div_quo)
   );

   fcr_tach_bank #(
      .FAN_COUNT (FAN_COUNT),
      .IDX_W     (IDX_W)
   ) u_tach (
      .clock (clock),
      .reset (reset),
      .ctrl  (tach_ctrl),
      .sel   (tach_sel),
      .count (tach_count)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_sample_ok = rsp_ok_ff;
   assign rsp_duty_byte = rsp_duty_ff;
   assign rsp_pwm_level = rsp_pwm_ff;
   assign rsp_fan_id    = rsp_fan_ff;
   assign rsp_rpm_value = rsp_rpm_ff;
   assign rsp_last      = rsp_last_ff;

   `FCR_ASSERT_IMPLY(a_div_start_idle, clock, reset, div_start, !div_stat.busy)
   `FCR_ASSERT_IMPLY(a_load_when_free, clock, reset, out_load, !rsp_valid_ff || !rsp_stall)
   `FCR_ASSERT_IMPLY(a_done_awaited, clock, reset, div_stat.done, div_wait)
   `FCR_ASSERT_NEXT(a_duty_is_last, clock, reset, duty_load, rsp_valid && rsp_last && rsp_kind == KIND_DUTY)

endmodule

`default_nettype wire

/* bench/tb_fan_curve_and_tach_rpm.sv */
// Self-checking testbench for fan_curve_and_tach_rpm: directed table, then random traffic.
// Duty and rpm results are checked against the bench's model or a typed row's table values.
// Depends on fcr_pkg and the fan_curve_and_tach_rpm RTL.
module tb_fan_curve_and_tach_rpm;
   timeunit 1ns;
   timeprecision 1ps;

   import fcr_pkg::*;

   localparam int FANS = 2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int unsigned ITEM_TARGET = 1800;
   localparam int unsigned SETTLE_CYCLES = 100;
   localparam int unsigned CYCLE_LIMIT = 3_000_000;

   typedef struct packed {
      logic        kind;
      logic        sample_ok;
      logic [7:0]  duty_byte;
      logic [9:0]  pwm_level;
      logic        fan_id;
      logic [15:0] rpm_value;
      logic        last;
   } reading_type;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [11:0] sample;
      logic               fan;
      logic [15:0]        win;
      logic               typed;
      logic               exp_ok;
      logic [7:0]         exp_duty;
      logic [9:0]         exp_pwm;
      logic [15:0]        exp_rpm;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_func = '0;
   logic signed [11:0] req_temp_sample = '0;
   logic req_fan_select = 1'b0;
   logic [15:0] req_window_ms = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_kind;
   logic rsp_sample_ok;
   logic [7:0] rsp_duty_byte;
   logic [9:0] rsp_pwm_level;
   logic rsp_fan_id;
   logic [15:0] rsp_rpm_value;
   logic rsp_last;

   logic signed [11:0] curve_low = TEMP_LOW_RESET;
   logic signed [11:0] curve_high = TEMP_HIGH_RESET;
   logic signed [11:0] held_temp = '0;
   logic [15:0] pulses [FANS] = '{default: '0};

   reading_type staged[$];
   reading_type due_readings[$];
   bit calm_phase = 1'b0;
   int unsigned stall_hold = 0;
   int unsigned cycle_count = 0;
   int fail_count = 0;

   plan_row_type plan [0:24] = '{
      '{FUNC_TEMP,    12'sd0,     1'b0, 16'd0,     1'b1, 1'b1, 8'd0,   10'd0,    16'd0},
      '{FUNC_TEMP,    12'sd2047,  1'b0, 16'd0,     1'b1, 1'b1, 8'd255, 10'd1000, 16'd0},
      '{FUNC_TEMP,    12'h800,    1'b0, 16'd0,     1'b1, 1'b0, 8'd255, 10'd1000, 16'd0},
      '{FUNC_TEMP,    -12'sd800,  1'b0, 16'd0,     1'b1, 1'b0, 8'd255, 10'd1000, 16'd0},
      '{FUNC_TEMP,    -12'sd799,  1'b0, 16'd0,     1'b1, 1'b1, 8'd0,   10'd0,    16'd0},
      '{FUNC_TEMP,    12'sd1360,  1'b0, 16'd0,     1'b1, 1'b0, 8'd0,   10'd0,    16'd0},
      '{FUNC_TEMP,    -12'sd2032, 1'b0, 16'd0,     1'b1, 1'b0, 8'd0,   10'd0,    16'd0},
      '{FUNC_TEMP,    12'sd640,   1'b0, 16'd0,     1'b1, 1'b1, 8'd255, 10'd1000, 16'd0},
      '{FUNC_TEMP,    12'sd400,   1'b0, 16'd0,     1'b1, 1'b1, 8'd0,   10'd0,    16'd0},
      '{FUNC_TEMP,    12'sd401,   1'b0, 16'd0,     1'b1, 1'b1, 8'd51,  10'd200,  16'd0},
      '{FUNC_TEMP,    12'sd639,   1'b0, 16'd0,     1'b0, 1'b0, 8'd0,   10'd0,    16'd0},
      '{FUNC_TEMP,    12'sd1359,  1'b0, 16'd0,     1'b0, 1'b0, 8'd0,   10'd0,    16'd0},
      '{FUNC_MEASURE, 12'sd0,     1'b0, 16'd0,     1'b1, 1'b0, 8'd0,   10'd0,    16'hFFFF},
      '{FUNC_MEASURE, 12'sd0,     1'b0, 16'd1000,  1'b1, 1'b0, 8'd0,   10'd0,    16'd0},
      '{FUNC_TACH,    12'sd0,     1'b0, 16'd0,     1'b0, 1'b0, 8'd0,   10'd0,    16'd0},
      '{FUNC_TACH,    12'sd0,     1'b1, 16'd0,     1'b0, 1'b0, 8'd0,   10'd0,    16'd0},
      '{FUNC_TACH,    12'sd0,     1'b1, 16'd0,     1'b0, 1'b0, 8'd0,   10'd0,    16'd0},
      '{FUNC_MEASURE, 12'sd0,     1'b0, 16'hFFFF,  1'b0, 1'b0, 8'd0,   10'd0,    16'd0},
      '{FUNC_TACH,    12'sd0,     1'b1, 16'd0,     1'b0, 1'b0, 8'd0,   10'd0,    16'd0},
      '{FUNC_MEASURE, 12'sd0,     1'b0, 16'd1,     1'b0, 1'b0, 8'd0,   10'd0,    16'd0},
      '{FUNC_UNUSED,  -12'sd1,    1'b1, 16'hFFFF,  1'b0, 1'b0, 8'd0,   10'd0,    16'd0},
      '{FUNC_TACH,    12'sd0,     1'b0, 16'd0,     1'b0, 1'b0, 8'd0,   10'd0,    16'd0},
      '{FUNC_MEASURE, 12'sd0,     1'b0, 16'd0,     1'b1, 1'b0, 8'd0,   10'd0,    16'hFFFF},
      '{FUNC_MEASURE, 12'sd0,     1'b0, 16'hFFFF,  1'b1, 1'b0, 8'd0,   10'd0,    16'd0},
      '{FUNC_TEMP,    -12'sd2033, 1'b0, 16'd0,     1'b0, 1'b0, 8'd0,   10'd0,    16'd0}
   };

   fan_curve_and_tach_rpm #(
      .FAN_COUNT(FANS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_temp_sample(req_temp_sample),
      .req_fan_select(req_fan_select),
      .req_window_ms(req_window_ms),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_sample_ok(rsp_sample_ok),
      .rsp_duty_byte(rsp_duty_byte),
      .rsp_pwm_level(rsp_pwm_level),
      .rsp_fan_id(rsp_fan_id),
      .rsp_rpm_value(rsp_rpm_value),
      .rsp_last(rsp_last)
   );

   always #5 clock = ~clock;

   function automatic plan_row_type make_row(input logic [1:0] func, input logic [11:0] sample,
                                             input logic fan, input logic [15:0] win);
      plan_row_type row;
      row = '0;
      row.func = func;
      row.sample = sample;
      row.fan = fan;
      row.win = win;
      return row;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (calm_phase || r < 45) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic logic [15:0] pick_window();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 12) return $urandom_range(3);
      if (r < 45) return $urandom_range(200, 1);
      if (r < 85) return $urandom_range(5000, 200);
      return $urandom;
   endfunction

   task automatic predict_readings(input plan_row_type row);
      reading_type r;
      logic accepted;
      int t, tl, th, d;
      longint unsigned count, span, rate;
      r = '0;
      case (row.func)
         FUNC_TEMP: begin
            accepted = (row.sample > TEMP_FLOOR) && (row.sample != TEMP_ERR_HOT) &&
                       (row.sample != TEMP_ERR_COLD);
            if (accepted) held_temp = row.sample;
            t = held_temp;
            tl = curve_low;
            th = curve_high;
            if (t >= th) d = 255;
            else if (t <= tl) d = 0;
            else d = 51 + ((t - tl) * 204) / (th - tl);
            r.kind = KIND_DUTY;
            r.sample_ok = accepted;
            r.duty_byte = d;
            r.pwm_level = (d * 1000) / 255;
            r.last = 1'b1;
            staged.push_back(r);
         end
         FUNC_TACH: begin
            if (pulses[row.fan] != COUNT_MAX) pulses[row.fan] = pulses[row.fan] + 16'd1;
         end
         FUNC_MEASURE: begin
            for (int i = 0; i < FANS; i++) begin
               count = pulses[i];
               span = row.win;
               if (span == 0) rate = 65535;
               else rate = (count * 60000) / (2 * span);
               if (rate > 65535) rate = 65535;
               pulses[i] = '0;
               r = '0;
               r.kind = KIND_RPM;
               r.fan_id = i;
               r.rpm_value = rate;
               r.last = (i == FANS - 1);
               staged.push_back(r);
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic send_item(input plan_row_type row);
      reading_type e;
      int unsigned gap;
      req_valid <= 1'b1;
      req_func <= row.func;
      req_temp_sample <= row.sample;
      req_fan_select <= row.fan;
      req_window_ms <= row.win;
      do @(posedge clock); while (req_stall);
      predict_readings(row);
      while (staged.size() != 0) begin
         e = staged.pop_front();
         if (row.typed) begin
            if (e.kind == KIND_DUTY) begin
               e.sample_ok = row.exp_ok;
               e.duty_byte = row.exp_duty;
               e.pwm_level = row.exp_pwm;
            end else begin
               e.rpm_value = row.exp_rpm;
            end
         end
         due_readings.push_back(e);
      end
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results(input int unsigned extra);
      req_valid <= 1'b0;
      while (due_readings.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_csr(input logic reg_idx, input logic signed [11:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_idx, 2'b00};
      pwdata <= {{20{value[11]}}, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (reg_idx == REG_TEMP_LOW) curve_low = value;
      else curve_high = value;
      @(posedge clock);
   endtask

   task automatic run_random_traffic();
      int unsigned sent, next_retune, next_drain, phase, r, n;
      int lo, hi;
      logic signed [11:0] s, a, b;
      logic seq_fan;
      sent = 0;
      next_retune = 0;
      next_drain = 150;
      phase = 0;
      while (sent < ITEM_TARGET) begin
         calm_phase = (sent % 300) >= 240;
         if (sent >= next_retune) begin
            drain_results(SETTLE_CYCLES);
            case (phase % 8)
               0: begin a = 12'h800; b = 12'sd2047; end
               1: begin a = 12'sd2047; b = 12'h800; end
               2: begin a = 12'sd300; b = 12'sd300; end
               3: begin a = 12'sd399; b = 12'sd400; end
               4: begin a = -12'sd800; b = 12'sd1360; end
               5: begin a = TEMP_LOW_RESET; b = TEMP_HIGH_RESET; end
               6: begin a = $urandom; b = $urandom; end
               default: begin a = $urandom; b = a + 12'($urandom_range(8, 1)); end
            endcase
            write_csr(REG_TEMP_LOW, a);
            write_csr(REG_TEMP_HIGH, b);
            phase++;
            next_retune += 200;
         end else if (sent >= next_drain) begin
            drain_results(0);
            next_drain += 150;
         end
         r = $urandom_range(99);
         if (r < 40) begin
            r = $urandom_range(99);
            if (r < 50) begin
               lo = (curve_low < curve_high) ? curve_low : curve_high;
               hi = (curve_low < curve_high) ? curve_high : curve_low;
               lo = (lo - 16 < -2048) ? -2048 : lo - 16;
               hi = (hi + 16 > 2047) ? 2047 : hi + 16;
               s = lo + int'($urandom_range(hi - lo));
            end else if (r < 65) begin
               case ($urandom_range(9))
                  0: s = -12'sd800;
                  1: s = -12'sd799;
                  2: s = 12'sd1360;
                  3: s = 12'sd1359;
                  4: s = 12'sd1361;
                  5: s = -12'sd2032;
                  6: s = -12'sd2031;
                  7: s = 12'h800;
                  8: s = 12'sd2047;
                  default: s = -12'sd801;
               endcase
            end else begin
               s = $urandom;
            end
            send_item(make_row(FUNC_TEMP, s, $urandom, $urandom));
            sent++;
         end else if (r < 85) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(400, 60) : $urandom_range(25);
            seq_fan = $urandom;
            for (int k = 0; k < n; k++) begin
               send_item(make_row(FUNC_TACH, $urandom,
                                  ($urandom_range(3) != 0) ? seq_fan : ~seq_fan, $urandom));
            end
            send_item(make_row(FUNC_MEASURE, $urandom, $urandom, pick_window()));
            sent += n + 1;
         end else if (r < 92) begin
            send_item(make_row(FUNC_TACH, $urandom, $urandom, $urandom));
            sent++;
         end else if (r < 97) begin
            send_item(make_row(FUNC_MEASURE, $urandom, $urandom, pick_window()));
            sent++;
         end else begin
            send_item(make_row(FUNC_UNUSED, $urandom, $urandom, $urandom));
         end
      end
      calm_phase = 1'b0;
   endtask

   always @(posedge clock) begin
      if (stall_hold != 0) begin
         stall_hold--;
      end else if (calm_phase) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 35);
         stall_hold = ($urandom_range(99) < 4) ? $urandom_range(80, 20) : $urandom_range(3);
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch_results
      reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_readings.size() == 0) begin
            fail_count++;
            $display("%0t: result transaction with nothing expected, actual kind %0d",
                     $time, rsp_kind);
         end else begin
            want = due_readings.pop_front();
            check_field("kind", want.kind, rsp_kind);
            check_field("sample_ok", want.sample_ok, rsp_sample_ok);
            check_field("duty_byte", want.duty_byte, rsp_duty_byte);
            check_field("pwm_level", want.pwm_level, rsp_pwm_level);
            check_field("fan_id", want.fan_id, rsp_fan_id);
            check_field("rpm_value", want.rpm_value, rsp_rpm_value);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, due_readings.size());
         $display("fan_curve_and_tach_rpm regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (plan[k]) send_item(plan[k]);
      drain_results(0);
      run_random_traffic();
      drain_results(SETTLE_CYCLES);
      if (fail_count == 0) begin
         $display("fan_curve_and_tach_rpm regression: pass");
      end else begin
         $display("fan_curve_and_tach_rpm regression: fail");
      end
      $finish;
   end

endmodule
